@@ sv/pcsb_pkg.sv @@
// shared constants, types and tables of the point to scan min-range binner
// used by pcsb_ctrl, pcsb_datapath and point_cloud_to_scan_binning_top
package pcsb_pkg;

    localparam int NUM_BINS     = 512;
    localparam int BIN_W        = $clog2(NUM_BINS);
    localparam int COORD_W      = 24;
    localparam int RANGE_W      = 24;
    localparam int SEL_W        = 9;
    localparam int STATUS_W     = 3;
    localparam int ANGLE_W      = 16;
    localparam int HEIGHT_W     = 24;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 24;
    localparam int CNT_W        = (BIN_W > 5) ? BIN_W : 5;
    localparam int MUL_W        = (COORD_W > RANGE_W) ? COORD_W : RANGE_W;
    localparam int SQ_W         = 2 * MUL_W + 1;
    localparam int SQRT_STEPS   = COORD_W;
    localparam int SCALE_SH     = 24;
    localparam int CX_W         = COORD_W + SCALE_SH + 3;
    localparam int Z_W          = 34;
    localparam int CORDIC_STEPS = 28;
    localparam int DIVD_W       = ANGLE_W + 1;
    localparam int MUL_STEPS    = 4;
    localparam int SAT_RANGE    = (1 << RANGE_W) - 1;

    localparam logic [STATUS_W-1:0] ST_LOWERED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_KEPT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HEIGHT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NEAR    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FAR     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ANGLE   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_READOUT = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOWER = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_UPPER = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_END   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_VALUE = 4'd7;

    typedef enum logic [3:0] {
        DP_NONE, DP_CLEAR, DP_LOAD, DP_MUL, DP_SQRT, DP_CHECK, DP_CINIT, DP_CORDIC,
        DP_ANGLE, DP_DIV, DP_DIV_B, DP_BIN, DP_MEM_READ, DP_UPDATE, DP_DELIVER
    } t_dp_op;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_MUL, S_SQRT, S_CHECK, S_CINIT, S_CORDIC,
        S_ANGLE, S_DIV, S_DIV_B, S_BIN, S_MEM_READ, S_UPDATE, S_DONE
    } t_state;

    typedef struct packed {
        t_dp_op           op;
        logic [CNT_W-1:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
        logic is_invalid;
        logic range_reject;
        logic angle_reject;
    } t_dp_sts;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [Z_W-1:0] atan_lut(input logic [4:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(536870912);
            5'd1:    v = Z_W'(316933406);
            5'd2:    v = Z_W'(167458907);
            5'd3:    v = Z_W'(85004756);
            5'd4:    v = Z_W'(42667331);
            5'd5:    v = Z_W'(21354465);
            5'd6:    v = Z_W'(10679838);
            5'd7:    v = Z_W'(5340245);
            5'd8:    v = Z_W'(2670163);
            5'd9:    v = Z_W'(1335087);
            5'd10:   v = Z_W'(667544);
            5'd11:   v = Z_W'(333772);
            5'd12:   v = Z_W'(166886);
            5'd13:   v = Z_W'(83443);
            5'd14:   v = Z_W'(41722);
            5'd15:   v = Z_W'(20861);
            5'd16:   v = Z_W'(10430);
            5'd17:   v = Z_W'(5215);
            5'd18:   v = Z_W'(2608);
            5'd19:   v = Z_W'(1304);
            5'd20:   v = Z_W'(652);
            5'd21:   v = Z_W'(326);
            5'd22:   v = Z_W'(163);
            5'd23:   v = Z_W'(81);
            5'd24:   v = Z_W'(41);
            5'd25:   v = Z_W'(20);
            5'd26:   v = Z_W'(10);
            5'd27:   v = Z_W'(5);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/pcsb_ctrl.sv @@
// sequencing state machine of the binner: handshakes, step counts, clearing pass
// depends on pcsb_pkg
module pcsb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  pcsb_pkg::t_dp_sts i_sts,
    output pcsb_pkg::t_dp_cmd o_cmd
);
    import pcsb_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_div_b, n_div_b;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_div_b     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_div_b     <= n_div_b;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        n_div_b = r_div_b;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == CNT_W'(NUM_BINS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_cnt = '0;
                if (i_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_cnt = '0;
                if (i_sts.is_read) begin
                    n_state = S_MEM_READ;
                end else if (i_sts.is_invalid) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_state = S_SQRT;
                    n_cnt   = '0;
                end
            end
            S_SQRT: begin
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.range_reject ? S_DONE : S_CINIT;
            end
            S_CINIT: begin
                n_state = S_CORDIC;
                n_cnt   = '0;
            end
            S_CORDIC: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                n_cnt   = '0;
                n_div_b = 1'b0;
                n_state = i_sts.angle_reject ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    n_state = r_div_b ? S_BIN : S_DIV_B;
                end
            end
            S_DIV_B: begin
                n_cnt   = '0;
                n_div_b = 1'b1;
                n_state = S_DIV;
            end
            S_BIN:      n_state = S_MEM_READ;
            S_MEM_READ: n_state = S_UPDATE;
            S_UPDATE:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op    = DP_NONE;
        o_cmd.cnt   = r_cnt;
        o_ready     = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            S_CLEAR:    o_cmd.op = DP_CLEAR;
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = DP_LOAD;
                end
            end
            S_DISPATCH: o_cmd.op = DP_NONE;
            S_MUL:      o_cmd.op = DP_MUL;
            S_SQRT:     o_cmd.op = DP_SQRT;
            S_CHECK:    o_cmd.op = DP_CHECK;
            S_CINIT:    o_cmd.op = DP_CINIT;
            S_CORDIC:   o_cmd.op = DP_CORDIC;
            S_ANGLE:    o_cmd.op = DP_ANGLE;
            S_DIV:      o_cmd.op = DP_DIV;
            S_DIV_B:    o_cmd.op = DP_DIV_B;
            S_BIN:      o_cmd.op = DP_BIN;
            S_MEM_READ: o_cmd.op = DP_MEM_READ;
            S_UPDATE:   o_cmd.op = DP_UPDATE;
            S_DONE: begin
                if (out_free) begin
                    o_cmd.op    = DP_DELIVER;
                    n_out_valid = 1'b1;
                end
            end
            default:    o_cmd.op = DP_NONE;
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

@@ sv/pcsb_datapath.sv @@
// datapath of the binner: config registers, squarer, root, cordic, divider, bin memory
// depends on pcsb_pkg
module pcsb_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcsb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcsb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_operation,
    input  logic signed [pcsb_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [pcsb_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [pcsb_pkg::COORD_W-1:0] i_point_z,
    input  logic                                i_point_invalid,
    input  logic [pcsb_pkg::SEL_W-1:0]          i_bin_select,
    input  pcsb_pkg::t_dp_cmd                   i_cmd,
    output pcsb_pkg::t_dp_sts                   o_sts,
    output logic [pcsb_pkg::STATUS_W-1:0]       o_status,
    output logic [pcsb_pkg::SEL_W-1:0]          o_bin_index,
    output logic [pcsb_pkg::RANGE_W-1:0]        o_range_value
);
    import pcsb_pkg::*;

    // configuration
    logic signed [HEIGHT_W-1:0] r_min_height, r_max_height;
    logic [RANGE_W-1:0]         r_range_lower, r_range_upper, r_empty_value;
    logic signed [ANGLE_W-1:0]  r_angle_start, r_angle_end;
    logic [ANGLE_W-1:0]         r_angle_step;

    // item
    logic                       r_op, r_inv;
    logic signed [COORD_W-1:0]  r_px, r_py, r_pz;
    logic [COORD_W-1:0]         r_ax, r_ay;
    logic [SEL_W-1:0]           r_sel;

    // working
    logic [SQ_W-1:0]            r_s, r_rl2, r_ru2, r_rem, r_root, r_bit;
    logic signed [CX_W-1:0]     r_x, r_y;
    logic signed [Z_W-1:0]      r_z;
    logic                       r_origin;
    logic [DIVD_W-1:0]          r_dq, r_drem, r_nb;
    logic [BIN_W-1:0]           r_addr;
    logic [RANGE_W:0]           r_rd;
    logic [STATUS_W-1:0]        r_status;
    logic [SEL_W-1:0]           r_idx;
    logic [RANGE_W-1:0]         r_range;

    logic [RANGE_W:0]           r_mem [NUM_BINS];

    logic [MUL_W-1:0]           mul_a;
    logic [2*MUL_W-1:0]         prod;
    logic [SQ_W-1:0]            trial_sq;
    logic [RANGE_W-1:0]         root_sat;
    logic                       hgt_rej, near_rej, far_rej;
    logic signed [CX_W-1:0]     x0, y0, dx, dy;
    logic [4:0]                 sh;
    logic [Z_W-1:0]             z_rnd;
    logic signed [ANGLE_W-1:0]  ang;
    logic [ANGLE_W-1:0]         step_e, span, ang_off;
    logic [DIVD_W:0]            trial_div;
    logic [DIVD_W-1:0]          nb_c, bin_c;
    logic                       sel_ok, lower, mem_we;
    logic [RANGE_W:0]           mem_wd;
    logic [BIN_W-1:0]           mem_wa;
    logic [RANGE_W-1:0]         upd_range;
    logic [STATUS_W-1:0]        upd_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_height  <= '0;
            r_max_height  <= HEIGHT_W'(8388607);
            r_range_lower <= '0;
            r_range_upper <= RANGE_W'(SAT_RANGE);
            r_angle_start <= ANGLE_W'(-32768);
            r_angle_end   <= ANGLE_W'(32767);
            r_angle_step  <= ANGLE_W'(182);
            r_empty_value <= RANGE_W'(SAT_RANGE);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_HEIGHT:  r_min_height  <= HEIGHT_W'(i_cfg_data);
                CFG_MAX_HEIGHT:  r_max_height  <= HEIGHT_W'(i_cfg_data);
                CFG_RANGE_LOWER: r_range_lower <= RANGE_W'(i_cfg_data);
                CFG_RANGE_UPPER: r_range_upper <= RANGE_W'(i_cfg_data);
                CFG_ANGLE_START: r_angle_start <= ANGLE_W'(i_cfg_data);
                CFG_ANGLE_END:   r_angle_end   <= ANGLE_W'(i_cfg_data);
                CFG_ANGLE_STEP:  r_angle_step  <= ANGLE_W'(i_cfg_data);
                CFG_EMPTY_VALUE: r_empty_value <= RANGE_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // squarer operand
    always_comb begin
        case (i_cmd.cnt[1:0])
            2'd0:    mul_a = MUL_W'(r_ax);
            2'd1:    mul_a = MUL_W'(r_ay);
            2'd2:    mul_a = MUL_W'(r_range_lower);
            default: mul_a = MUL_W'(r_range_upper);
        endcase
    end
    assign prod = mul_a * mul_a;

    assign trial_sq = r_root + r_bit;
    assign root_sat = (r_root > SQ_W'(SAT_RANGE)) ? RANGE_W'(SAT_RANGE) : RANGE_W'(r_root);
    assign hgt_rej  = (r_pz > r_max_height) || (r_pz < r_min_height);
    assign near_rej = r_s < r_rl2;
    assign far_rej  = r_s > r_ru2;

    // cordic pre-rotation into the right half plane
    assign x0 = CX_W'(r_px) <<< SCALE_SH;
    assign y0 = CX_W'(r_py) <<< SCALE_SH;
    assign sh = i_cmd.cnt[4:0];
    assign dx = r_y >>> sh;
    assign dy = r_x >>> sh;
    assign z_rnd = r_z + Z_W'(32768);
    assign ang = r_origin ? '0 : $signed(z_rnd[ANGLE_W+15:16]);

    assign step_e  = (r_angle_step == '0) ? ANGLE_W'(1) : r_angle_step;
    assign span    = ANGLE_W'(r_angle_end - r_angle_start);
    assign ang_off = ANGLE_W'(ang - r_angle_start);
    assign trial_div = {r_drem, r_dq[DIVD_W-1]};

    assign nb_c  = (r_nb == '0) ? DIVD_W'(1)
                 : ((r_nb > DIVD_W'(NUM_BINS)) ? DIVD_W'(NUM_BINS) : r_nb);
    assign bin_c = (r_dq > nb_c - DIVD_W'(1)) ? nb_c - DIVD_W'(1) : r_dq;

    // bin update
    always_comb begin
        sel_ok     = 32'(r_sel) < NUM_BINS;
        lower      = !r_rd[RANGE_W] || (r_range < r_rd[RANGE_W-1:0]);
        mem_we     = 1'b0;
        mem_wd     = '0;
        mem_wa     = r_addr;
        upd_range  = r_range;
        upd_status = ST_KEPT;
        if (i_cmd.op == DP_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = BIN_W'(i_cmd.cnt);
        end else if (i_cmd.op == DP_UPDATE) begin
            if (r_op) begin
                upd_status = ST_READOUT;
                upd_range  = (sel_ok && r_rd[RANGE_W]) ? r_rd[RANGE_W-1:0] : r_empty_value;
                mem_we     = sel_ok;
                mem_wd     = {1'b0, r_rd[RANGE_W-1:0]};
            end else begin
                upd_status = lower ? ST_LOWERED : ST_KEPT;
                mem_we     = lower;
                mem_wd     = {1'b1, r_range};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.op == DP_MEM_READ) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_op     <= i_operation;
                r_inv    <= i_point_invalid;
                r_px     <= i_point_x;
                r_py     <= i_point_y;
                r_pz     <= i_point_z;
                r_ax     <= (i_point_x < 0) ? COORD_W'(-i_point_x) : COORD_W'(i_point_x);
                r_ay     <= (i_point_y < 0) ? COORD_W'(-i_point_y) : COORD_W'(i_point_y);
                r_sel    <= i_bin_select;
                r_addr   <= BIN_W'(i_bin_select);
                r_idx    <= i_operation ? i_bin_select : '0;
                r_range  <= '0;
                r_status <= ST_INVALID;
            end
            DP_MUL: begin
                case (i_cmd.cnt[1:0])
                    2'd0: r_s   <= SQ_W'(prod);
                    2'd1: r_s   <= r_s + SQ_W'(prod);
                    2'd2: r_rl2 <= SQ_W'(prod);
                    default: begin
                        r_ru2  <= SQ_W'(prod);
                        r_rem  <= r_s;
                        r_root <= '0;
                        r_bit  <= SQ_W'(1) << (2 * COORD_W - 2);
                    end
                endcase
            end
            DP_SQRT: begin
                if (r_rem >= trial_sq) begin
                    r_rem  <= r_rem - trial_sq;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            DP_CHECK: begin
                r_range <= root_sat;
                if (hgt_rej) begin
                    r_status <= ST_HEIGHT;
                end else if (near_rej) begin
                    r_status <= ST_NEAR;
                end else begin
                    r_status <= ST_FAR;
                end
            end
            DP_CINIT: begin
                r_origin <= (r_px == '0) && (r_py == '0);
                if (x0 < 0) begin
                    if (y0 >= 0) begin
                        r_x <= y0;
                        r_y <= -x0;
                        r_z <= Z_W'(1 << 30);
                    end else begin
                        r_x <= -y0;
                        r_y <= x0;
                        r_z <= -Z_W'(1 << 30);
                    end
                end else begin
                    r_x <= x0;
                    r_y <= y0;
                    r_z <= '0;
                end
            end
            DP_CORDIC: begin
                if (r_y > 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + $signed(atan_lut(sh));
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - $signed(atan_lut(sh));
                end
            end
            DP_ANGLE: begin
                r_status <= ST_ANGLE;
                r_dq     <= DIVD_W'(span) + DIVD_W'(step_e) - DIVD_W'(1);
                r_drem   <= '0;
            end
            DP_DIV: begin
                if (trial_div >= (DIVD_W + 1)'(step_e)) begin
                    r_drem <= DIVD_W'(trial_div - (DIVD_W + 1)'(step_e));
                    r_dq   <= {r_dq[DIVD_W-2:0], 1'b1};
                end else begin
                    r_drem <= DIVD_W'(trial_div);
                    r_dq   <= {r_dq[DIVD_W-2:0], 1'b0};
                end
            end
            DP_DIV_B: begin
                r_nb   <= r_dq;
                r_dq   <= DIVD_W'(ang_off);
                r_drem <= '0;
            end
            DP_BIN: begin
                r_addr <= BIN_W'(bin_c);
                r_idx  <= SEL_W'(bin_c);
            end
            DP_UPDATE: begin
                r_range  <= upd_range;
                r_status <= upd_status;
            end
            DP_DELIVER: begin
                o_status      <= r_status;
                o_bin_index   <= r_idx;
                o_range_value <= r_range;
            end
            default: ;
        endcase
    end

    assign o_sts.is_read      = r_op;
    assign o_sts.is_invalid   = r_inv;
    assign o_sts.range_reject = hgt_rej || near_rej || far_rej;
    assign o_sts.angle_reject = (ang < r_angle_start) || (ang > r_angle_end);

endmodule

@@ sv/point_cloud_to_scan_binning_top.sv @@
// point to scan min-range binner, top level: one item in flight at a time
// each kind of item runs its own sequence of steps: add point, angle reject,
// height or range reject, invalid point, readout; next item taken the cycle after result loads
// a result not yet taken holds the block; config writes are always taken
// reset is synchronous active low, then a pass clearing all NUM_BINS bins before the first item
// depends on pcsb_pkg, pcsb_ctrl, pcsb_datapath
module point_cloud_to_scan_binning_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcsb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcsb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_operation,
    input  logic signed [pcsb_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [pcsb_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [pcsb_pkg::COORD_W-1:0] i_point_z,
    input  logic                                i_point_invalid,
    input  logic [pcsb_pkg::SEL_W-1:0]          i_bin_select,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pcsb_pkg::STATUS_W-1:0]       o_status,
    output logic [pcsb_pkg::SEL_W-1:0]          o_bin_index,
    output logic [pcsb_pkg::RANGE_W-1:0]        o_range_value
);
    import pcsb_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    pcsb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pcsb_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_z       (i_point_z),
        .i_point_invalid (i_point_invalid),
        .i_bin_select    (i_bin_select),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_status        (o_status),
        .o_bin_index     (o_bin_index),
        .o_range_value   (o_range_value)
    );

endmodule
